>>> sv/bpwa_pkg.sv
package bpwa_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int MAX_WAITERS = 255;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int WAIT_W = $clog2(MAX_WAITERS + 1);

    localparam int QB_W        = 30;
    localparam int RESERVE_SH  = 14;
    localparam int RESERVE_MIN = 16;
    localparam int RES_W       = QB_W - RESERVE_SH;

    localparam int MAX_BLOCKS_RESET   = 64;
    localparam int QUEUED_BYTES_RESET = 524288;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_BLOCKS   = 2'd0,
        REG_QUEUED_BYTES = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_SUBSCRIBE = 2'd2,
        OP_QUERY     = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

>>> sv/buffer_pool_watermark_allocator_top.sv
// Channel | Direction | Handshake                  | Payload
// command | in        | start & !busy              | opcode, slot_in, subscribe_on_pressure,
//         |           |                            | batch_end, needed_count
// result  | out       | done, one cycle            | granted, slot_out, pressure, start_trim,
//         |           |                            | evict_count, waiters_released, in_use_count
// config  | in        | cfg_we                     | cfg_index, cfg_data
//
// The free stack memory is read at the accepting edge and the item is executed,
// with any push written back, in the following cycle.
// The result appears on the cycle after that with done high, and a new item may be
// accepted in that same cycle; busy refuses a new item while one is executing.
// Reset needs no clearing pass: stack entries below the lowest top reached since the
// last reload have never been written, so their own index is given, not the memory data.
// The receiver cannot stall; results are presented for exactly one cycle.
module buffer_pool_watermark_allocator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      opcode,
    input  logic [bpwa_pkg::SLOT_W-1:0]     slot_in,
    input  logic                            subscribe_on_pressure,
    input  logic                            batch_end,
    input  logic [bpwa_pkg::CNT_W-1:0]      needed_count,
    output logic                            done,
    output logic                            granted,
    output logic [bpwa_pkg::SLOT_W-1:0]     slot_out,
    output logic                            pressure,
    output logic                            start_trim,
    output logic [bpwa_pkg::CNT_W-1:0]      evict_count,
    output logic [bpwa_pkg::WAIT_W-1:0]     waiters_released,
    output logic [bpwa_pkg::CNT_W-1:0]      in_use_count,
    input  logic                            cfg_we,
    input  logic [bpwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpwa_pkg::QB_W-1:0]       cfg_data
);

    localparam int SLOT_W = bpwa_pkg::SLOT_W;
    localparam int CNT_W  = bpwa_pkg::CNT_W;
    localparam int WAIT_W = bpwa_pkg::WAIT_W;
    localparam int QB_W   = bpwa_pkg::QB_W;
    localparam int RES_W  = bpwa_pkg::RES_W;
    localparam int SW     = CNT_W + 3;

    bpwa_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0] free_stack [bpwa_pkg::MAX_SLOTS];
    logic [SLOT_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  pool_reg, pool_next;
    logic [QB_W-1:0]   qbytes_reg, qbytes_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  min_top_reg, min_top_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              over_reg, over_next;
    logic [WAIT_W-1:0] waiter_reg, waiter_next;

    logic [1:0]        op_reg;
    logic [SLOT_W-1:0] slot_in_reg;
    logic              sub_reg;
    logic              batch_reg;
    logic [CNT_W-1:0]  needed_reg;

    logic              done_reg;
    logic              granted_reg, granted_next;
    logic [SLOT_W-1:0] slot_out_reg, slot_out_next;
    logic              trim_reg, trim_next;
    logic [CNT_W-1:0]  evict_reg, evict_next;
    logic [WAIT_W-1:0] released_reg, released_next;

    logic              accept;
    logic              exec;
    logic              push;
    logic [CNT_W-1:0]  cfg_pool;

    logic [RES_W-1:0]  reserve;
    logic [CNT_W-1:0]  low;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  high;
    logic [CNT_W-1:0]  used_inc;
    logic [CNT_W-1:0]  used_dec;
    logic [WAIT_W-1:0] waiter_inc;

    logic signed [SW-1:0] used_s, needed_s, pool_s, low_s, cap_s, lim_s;
    logic signed [SW-1:0] r_s, over_s;

    function automatic logic batch_end_check(input logic              be,
                                             input logic              ov,
                                             input logic [CNT_W-1:0]  used,
                                             input logic [CNT_W-1:0]  lo);
        return be && ov && (used <= lo);
    endfunction

    assign accept = start && (state_reg == bpwa_pkg::ST_IDLE);
    assign exec   = (state_reg == bpwa_pkg::ST_EXEC);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpwa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = bpwa_pkg::ST_EXEC;
                end
            end
            bpwa_pkg::ST_EXEC:
            begin
                state_next = bpwa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bpwa_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs.
    always_comb
    begin
        unique case (state_reg)
            bpwa_pkg::ST_IDLE: busy = 1'b0;
            bpwa_pkg::ST_EXEC: busy = 1'b1;
            default:           busy = 1'b1;
        endcase
    end

    // Watermarks follow the current registers.
    always_comb
    begin
        reserve = qbytes_reg[QB_W-1:bpwa_pkg::RESERVE_SH];
        if (reserve < RES_W'(bpwa_pkg::RESERVE_MIN))
        begin
            reserve = RES_W'(bpwa_pkg::RESERVE_MIN);
        end
        if ({{(RES_W-CNT_W){1'b0}}, pool_reg} > reserve)
        begin
            low = pool_reg - reserve[CNT_W-1:0];
        end
        else
        begin
            low = '0;
        end
        half = (pool_reg - low) >> 1;
        high = low + half;
    end

    assign used_inc   = used_reg + CNT_W'(1);
    assign used_dec   = used_reg - CNT_W'(1);
    assign waiter_inc = (waiter_reg < WAIT_W'(bpwa_pkg::MAX_WAITERS)) ?
                        waiter_reg + WAIT_W'(1) : waiter_reg;

    assign push = exec && (op_reg == bpwa_pkg::OP_FREE) && (used_reg != '0) &&
                  (top_reg < CNT_W'(bpwa_pkg::MAX_SLOTS));

    always_comb
    begin
        if ({{(QB_W-CNT_W){1'b0}}, cfg_data[CNT_W-1:0]} > QB_W'(bpwa_pkg::MAX_SLOTS))
        begin
            cfg_pool = CNT_W'(bpwa_pkg::MAX_SLOTS);
        end
        else
        begin
            cfg_pool = cfg_data[CNT_W-1:0];
        end
    end

    // Eviction query arithmetic, signed and wide enough for every difference.
    always_comb
    begin
        used_s   = SW'($signed({3'b000, used_reg}));
        needed_s = SW'($signed({3'b000, needed_reg}));
        pool_s   = SW'($signed({3'b000, pool_reg}));
        low_s    = SW'($signed({3'b000, low}));
        cap_s    = pool_s - SW'($signed({{(SW-WAIT_W){1'b0}}, waiter_reg}));
        lim_s    = (low_s < cap_s) ? low_s : cap_s;
        r_s      = over_reg ? (used_s - lim_s) : '0;
        over_s   = used_s + needed_s - pool_s;
        if (over_s > SW'(0) && over_s > r_s)
        begin
            r_s = over_s;
        end
        if (r_s < SW'(0))
        begin
            r_s = '0;
        end
        else if (r_s > used_s)
        begin
            r_s = used_s;
        end
    end

    // Item execution and configuration.
    always_comb
    begin
        pool_next     = pool_reg;
        qbytes_next   = qbytes_reg;
        top_next      = top_reg;
        min_top_next  = min_top_reg;
        used_next     = used_reg;
        over_next     = over_reg;
        waiter_next   = waiter_reg;
        granted_next  = 1'b0;
        slot_out_next = '0;
        trim_next     = 1'b0;
        evict_next    = '0;
        released_next = '0;

        if (exec)
        begin
            case (op_reg)
                bpwa_pkg::OP_ALLOC:
                begin
                    if (top_reg <= half)
                    begin
                        over_next = 1'b1;
                    end
                    if (top_reg != '0)
                    begin
                        top_next     = top_reg - CNT_W'(1);
                        granted_next = 1'b1;
                        used_next    = used_inc;
                        // Never written since the reload: the entry's own index is given, not the memory data.
                        if (min_top_reg == top_reg)
                        begin
                            slot_out_next = top_next[SLOT_W-1:0];
                            min_top_next  = top_next;
                        end
                        else
                        begin
                            slot_out_next = rd_data_reg;
                        end
                        if (used_inc >= high)
                        begin
                            over_next = 1'b1;
                        end
                    end
                    if (sub_reg && over_next)
                    begin
                        waiter_next = waiter_inc;
                        trim_next   = !over_reg;
                    end
                end
                bpwa_pkg::OP_FREE:
                begin
                    if (push)
                    begin
                        top_next  = top_reg + CNT_W'(1);
                        used_next = used_dec;
                    end
                    if (batch_end_check(batch_reg, over_reg, used_next, low))
                    begin
                        over_next     = 1'b0;
                        released_next = waiter_reg;
                        waiter_next   = '0;
                    end
                end
                bpwa_pkg::OP_SUBSCRIBE:
                begin
                    waiter_next = waiter_inc;
                end
                default:
                begin
                    evict_next = r_s[CNT_W-1:0];
                end
            endcase
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpwa_pkg::REG_MAX_BLOCKS:
                begin
                    pool_next    = cfg_pool;
                    top_next     = cfg_pool;
                    min_top_next = cfg_pool;
                    used_next    = '0;
                    if (cfg_pool == '0)
                    begin
                        over_next = 1'b1;
                    end
                end
                bpwa_pkg::REG_QUEUED_BYTES:
                begin
                    qbytes_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bpwa_pkg::ST_IDLE;
            pool_reg    <= CNT_W'(bpwa_pkg::MAX_BLOCKS_RESET);
            qbytes_reg  <= QB_W'(bpwa_pkg::QUEUED_BYTES_RESET);
            top_reg     <= CNT_W'(bpwa_pkg::MAX_BLOCKS_RESET);
            min_top_reg <= CNT_W'(bpwa_pkg::MAX_BLOCKS_RESET);
            used_reg    <= '0;
            over_reg    <= 1'b0;
            waiter_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pool_reg    <= pool_next;
            qbytes_reg  <= qbytes_next;
            top_reg     <= top_next;
            min_top_reg <= min_top_next;
            used_reg    <= used_next;
            over_reg    <= over_next;
            waiter_reg  <= waiter_next;
            done_reg    <= exec;
        end
    end

    // Captured item and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            slot_in_reg <= slot_in;
            sub_reg     <= subscribe_on_pressure;
            batch_reg   <= batch_end;
            needed_reg  <= needed_count;
        end
        if (exec)
        begin
            granted_reg  <= granted_next;
            slot_out_reg <= slot_out_next;
            trim_reg     <= trim_next;
            evict_reg    <= evict_next;
            released_reg <= released_next;
        end
    end

    // Free stack memory: the top entry is read as the item is accepted.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            free_stack[top_reg[SLOT_W-1:0]] <= slot_in_reg;
        end
        if (accept)
        begin
            rd_data_reg <= free_stack[top_reg[SLOT_W-1:0] - SLOT_W'(1)];
        end
    end

    assign done             = done_reg;
    assign granted          = granted_reg;
    assign slot_out         = slot_out_reg;
    assign pressure         = over_reg;
    assign start_trim       = trim_reg;
    assign evict_count      = evict_reg;
    assign waiters_released = released_reg;
    assign in_use_count     = used_reg;

endmodule
